// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/ntt_pkg.sv
// Shared types, constants and the pitch lookup for the note to tone timing block.
package ntt_pkg;

   localparam int BASE_W             = 13;
   localparam int PROD_W             = 21;
   localparam int DEN_W              = 8;
   localparam int REM_W              = 8;
   localparam int PITCH_W            = 12;
   localparam int DIV_STAGES         = 3;
   localparam int DIV_BITS_PER_STAGE = 7;
   localparam int SOUND_Q_W          = 18;
   localparam int GAP_Q_W            = 14;
   localparam int NINE_D_W           = 25;
   localparam int SCALE_PROD_W       = 40;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_DURATION = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_GAP        = 1'b1;
   localparam logic [BASE_W-1:0]      BASE_RESET        = 13'd4096;

   // floor(y / 5) = (y * DIV5_MUL) >> DIV5_SHIFT for every y below 2**20.
   localparam logic [19:0] DIV5_MUL   = 20'd838861;
   localparam int          DIV5_SHIFT = 22;

   localparam logic [15:0] SOUND_MAX = 16'hFFFF;
   localparam logic [12:0] GAP_MAX   = 13'h1FFF;

   localparam logic [7:0] OCTAVE_FOUR = 8'd4;
   localparam logic [7:0] OCTAVE_FIVE = 8'd5;
   localparam logic [7:0] OCTAVE_SIX  = 8'd6;
   localparam logic [3:0] LOW_COL_FIRST = 4'd9;

   localparam logic [PITCH_W-1:0] PITCH_LOWEST  = 12'd253;
   localparam logic [PITCH_W-1:0] PITCH_HIGHEST = 12'd2273;

   typedef struct packed {
      logic [7:0] note_letter;
      logic [7:0] octave;
      logic [7:0] length_num;
      logic [7:0] length_den;
   } req_payload_type;

   typedef struct packed {
      logic [PITCH_W-1:0] pitch_top;
      logic [15:0]        sound_ticks;
      logic [12:0]        gap_ticks;
      logic               bad_length;
   } rsp_payload_type;

   typedef struct packed {
      logic [PITCH_W-1:0] pitch;
      logic               bad;
      logic [DEN_W-1:0]   den;
      logic [PROD_W-1:0]  product;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_flags_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] idx;
   } col_type;

   // Rows are octaves 4, 5 and 6; columns are C c D d E F f G g A a B.
   localparam logic [PITCH_W-1:0] TONE_TAB [3][12] = '{
      '{12'd1915, 12'd1804, 12'd1703, 12'd1607, 12'd1517, 12'd1432,
        12'd1351, 12'd1276, 12'd1204, 12'd1136, 12'd1073, 12'd1012},
      '{12'd956,  12'd902,  12'd851,  12'd804,  12'd758,  12'd716,
        12'd676,  12'd638,  12'd602,  12'd568,  12'd536,  12'd506},
      '{12'd478,  12'd451,  12'd426,  12'd402,  12'd379,  12'd358,
        12'd338,  12'd319,  12'd301,  12'd284,  12'd268,  12'd253}
   };

   // Octave 3 exists only for A, a and B.
   localparam logic [PITCH_W-1:0] LOW_TAB [3] = '{12'd2273, 12'd2145, 12'd2025};

   function automatic col_type letter_column(input logic [7:0] letter);
      col_type c;
      c.hit = 1'b1;
      c.idx = 4'd0;
      case (letter)
         "C": c.idx = 4'd0;
         "c": c.idx = 4'd1;
         "D": c.idx = 4'd2;
         "d": c.idx = 4'd3;
         "E": c.idx = 4'd4;
         "F": c.idx = 4'd5;
         "f": c.idx = 4'd6;
         "G": c.idx = 4'd7;
         "g": c.idx = 4'd8;
         "A": c.idx = 4'd9;
         "a": c.idx = 4'd10;
         "B": c.idx = 4'd11;
         default: c.hit = 1'b0;
      endcase
      return c;
   endfunction

   function automatic logic [PITCH_W-1:0] pick_pitch(input logic [7:0] letter,
                                                     input logic [7:0] octave);
      col_type            c;
      logic [PITCH_W-1:0] top;
      c   = letter_column(letter);
      top = '0;
      if (c.hit) begin
         if (octave == OCTAVE_SIX) begin
            top = TONE_TAB[2][c.idx];
         end else if (octave == OCTAVE_FIVE) begin
            top = TONE_TAB[1][c.idx];
         end else if (c.idx >= LOW_COL_FIRST && octave != OCTAVE_FOUR) begin
            top = LOW_TAB[2'(c.idx - LOW_COL_FIRST)];
         end else begin
            top = TONE_TAB[0][c.idx];
         end
      end
      return top;
   endfunction

endpackage

// File: hdl/note_to_tone_timing.sv
// Top level of the note to tone timing block: configuration registers and the three parts.
// A record passes through the queue, three divider stages and one scaling stage,
// then the result register. Throughput: one record per cycle through the pipelined
// divider while rsp_stall is low.
// Reset (synchronous) empties the queue and pipeline and sets base_duration to 4096
// and no_gap to 0.
module note_to_tone_timing import ntt_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   logic [BASE_W-1:0] base_ff, base_in;
   logic              no_gap_ff, no_gap_in;
   q_flags_type       q_flags;
   logic              push;
   logic              pop;
   q_entry_type       push_entry;
   q_entry_type       head;

   always_comb begin
      base_in   = base_ff;
      no_gap_in = no_gap_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BASE_DURATION: base_in   = csr_wr_data[BASE_W-1:0];
            CSR_NO_GAP:        no_gap_in = csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= BASE_RESET;
         no_gap_ff <= 1'b0;
      end else begin
         base_ff   <= base_in;
         no_gap_ff <= no_gap_in;
      end
   end

   ntt_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .base_duration (base_ff),
      .q_flags       (q_flags),
      .push          (push),
      .push_entry    (push_entry)
   );

   ntt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .flags      (q_flags)
   );

   ntt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .no_gap      (no_gap_ff),
      .q_flags     (q_flags),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: hdl/ntt_front.sv
// Front end: accepts note records, looks up the pitch and forms the length product.
module ntt_front import ntt_pkg::*; (
   input  logic              req_valid,
   output logic              req_stall,
   input  req_payload_type   req_payload,
   input  logic [BASE_W-1:0] base_duration,
   input  q_flags_type       q_flags,
   output logic              push,
   output q_entry_type       push_entry
);

   assign req_stall = q_flags.full;
   assign push      = req_valid && !q_flags.full;

   always_comb begin
      push_entry.pitch   = pick_pitch(req_payload.note_letter, req_payload.octave);
      push_entry.bad     = (req_payload.length_den == '0);
      push_entry.den     = req_payload.length_den;
      push_entry.product = PROD_W'(base_duration) * PROD_W'(req_payload.length_num);
   end

endmodule

// File: hdl/ntt_queue.sv
// Small register queue between the front end and the duration back end.
module ntt_queue import ntt_pkg::*; #(
   parameter int unsigned DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   input  logic        pop,
   output q_entry_type head,
   output q_flags_type flags
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   q_entry_type   mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] ptr);
      return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign head        = mem_ff[rd_ptr_ff];
   assign flags.full  = (count_ff == CW'(DEPTH));
   assign flags.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: hdl/ntt_back.sv
// Back end: pipelined divide by the denominator, scaling to ticks and the result register.
module ntt_back import ntt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            no_gap,
   input  q_flags_type     q_flags,
   input  q_entry_type     head,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   typedef struct packed {
      logic [PITCH_W-1:0] pitch;
      logic               bad;
      logic [DEN_W-1:0]   den;
      logic [REM_W-1:0]   rem;
      logic [PROD_W-1:0]  work;
   } div_stage_type;

   typedef struct packed {
      logic [PITCH_W-1:0]   pitch;
      logic                 bad;
      logic [SOUND_Q_W-1:0] sound_q;
      logic [GAP_Q_W-1:0]   gap_q;
   } scale_stage_type;

   div_stage_type         div_ff [DIV_STAGES];
   div_stage_type         div_in [DIV_STAGES];
   logic [DIV_STAGES-1:0] div_v_ff, div_v_in;
   logic [DIV_STAGES-1:0] div_take;
   scale_stage_type       scale_ff, scale_in;
   logic                  scale_v_ff, scale_v_in;
   logic                  scale_take;
   rsp_payload_type       out_ff, out_in;
   logic                  out_v_ff, out_v_in;
   logic                  out_take;
   div_stage_type         div_start;
   logic [PROD_W-1:0]     quotient;
   logic [NINE_D_W-1:0]   nine_d;
   logic [SCALE_PROD_W-1:0] sound_prod;
   logic [SCALE_PROD_W-1:0] gap_prod;

   // Restoring division, a few quotient bits per stage. The dividend shifts out of
   // the top of work while the quotient shifts in at the bottom.
   function automatic div_stage_type div_chunk(input div_stage_type s);
      div_stage_type    r;
      logic [REM_W:0]   trial;
      r = s;
      for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
         trial  = {r.rem, r.work[PROD_W-1]};
         r.work = {r.work[PROD_W-2:0], 1'b0};
         if (trial >= {1'b0, r.den}) begin
            r.rem     = REM_W'(trial - {1'b0, r.den});
            r.work[0] = 1'b1;
         end else begin
            r.rem = trial[REM_W-1:0];
         end
      end
      return r;
   endfunction

   // A stage takes a new item when it is empty or its item moves on in this cycle.
   always_comb begin
      out_take   = !out_v_ff || !rsp_stall;
      scale_take = !scale_v_ff || out_take;
      div_take[DIV_STAGES-1] = !div_v_ff[DIV_STAGES-1] || scale_take;
      for (int i = DIV_STAGES - 2; i >= 0; i--) begin
         div_take[i] = !div_v_ff[i] || div_take[i+1];
      end
   end

   assign pop = !q_flags.empty && div_take[0];

   always_comb begin
      div_start.pitch = head.pitch;
      div_start.bad   = head.bad;
      div_start.den   = head.den;
      div_start.rem   = '0;
      div_start.work  = head.product;

      div_in[0]   = div_take[0] ? div_chunk(div_start) : div_ff[0];
      div_v_in[0] = div_take[0] ? !q_flags.empty : div_v_ff[0];
      for (int i = 1; i < DIV_STAGES; i++) begin
         div_in[i]   = div_take[i] ? div_chunk(div_ff[i-1]) : div_ff[i];
         div_v_in[i] = div_take[i] ? div_v_ff[i-1] : div_v_ff[i];
      end
   end

   // Sound is floor(9D/160) and gap is floor(D/160); both divide by 32 with a
   // shift and then by 5 with a reciprocal multiply.
   always_comb begin
      quotient   = div_ff[DIV_STAGES-1].work;
      nine_d     = (NINE_D_W'(quotient) << 3) + NINE_D_W'(quotient);
      sound_prod = SCALE_PROD_W'(nine_d[NINE_D_W-1:5]) * SCALE_PROD_W'(DIV5_MUL);
      gap_prod   = SCALE_PROD_W'(quotient[PROD_W-1:5]) * SCALE_PROD_W'(DIV5_MUL);

      scale_in = scale_ff;
      if (scale_take) begin
         scale_in.pitch   = div_ff[DIV_STAGES-1].pitch;
         scale_in.bad     = div_ff[DIV_STAGES-1].bad;
         scale_in.sound_q = sound_prod[DIV5_SHIFT +: SOUND_Q_W];
         scale_in.gap_q   = gap_prod[DIV5_SHIFT +: GAP_Q_W];
      end
      scale_v_in = scale_take ? div_v_ff[DIV_STAGES-1] : scale_v_ff;
   end

   always_comb begin
      out_in = out_ff;
      if (out_take) begin
         out_in.pitch_top  = scale_ff.pitch;
         out_in.bad_length = scale_ff.bad;
         if (scale_ff.bad) begin
            out_in.sound_ticks = '0;
         end else if (scale_ff.sound_q > SOUND_Q_W'(SOUND_MAX)) begin
            out_in.sound_ticks = SOUND_MAX;
         end else begin
            out_in.sound_ticks = scale_ff.sound_q[15:0];
         end
         if (scale_ff.bad || no_gap) begin
            out_in.gap_ticks = '0;
         end else if (scale_ff.gap_q > GAP_Q_W'(GAP_MAX)) begin
            out_in.gap_ticks = GAP_MAX;
         end else begin
            out_in.gap_ticks = scale_ff.gap_q[12:0];
         end
      end
      out_v_in = out_take ? scale_v_ff : out_v_ff;
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_v_ff   <= '0;
         scale_v_ff <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         div_v_ff   <= div_v_in;
         scale_v_ff <= scale_v_in;
         out_v_ff   <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
         div_ff[i] <= div_in[i];
      end
      scale_ff <= scale_in;
      out_ff   <= out_in;
   end

endmodule

// File: hdl/ntt_checker.sv
// Port-level checks on the result channel of the note to tone timing block.
`include "assert_macros.svh"

module ntt_checker import ntt_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   `ASSERT_CLK_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result after reset")
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload), "stalled result changed")
   `ASSERT_CLK(a_bad_zero, clock, reset, rsp_valid && rsp_payload.bad_length |-> rsp_payload.sound_ticks == '0 && rsp_payload.gap_ticks == '0, "zero denominator gave ticks")
   `ASSERT_CLK(a_pitch_range, clock, reset, rsp_valid |-> rsp_payload.pitch_top == '0 || (rsp_payload.pitch_top >= PITCH_LOWEST && rsp_payload.pitch_top <= PITCH_HIGHEST), "pitch top out of table range")
   `ASSERT_CLK(a_sound_ge_gap, clock, reset, rsp_valid |-> 16'(rsp_payload.gap_ticks) <= rsp_payload.sound_ticks, "gap longer than sound")

endmodule

bind note_to_tone_timing ntt_checker u_ntt_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
